/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define TACPU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true out of reset.
`define TACPU_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/tacpu_pkg.sv */
// Types, codes and constants of the tiny accumulator CPU execute block.
package tacpu_pkg;

	localparam int DataW = 8;
	localparam int RegCount = 4;
	localparam int RegAddrW = 2;
	localparam int ErrW = 2;

	// Error codes carried in a result beat.
	localparam logic [ErrW-1:0] ERR_NONE    = 2'd0;
	localparam logic [ErrW-1:0] ERR_OPCODE  = 2'd1;
	localparam logic [ErrW-1:0] ERR_DIVZERO = 2'd2;
	localparam logic [ErrW-1:0] ERR_HALTED  = 2'd3;

	// Operation selector of the arithmetic unit, instruction bits 5..4.
	localparam logic [1:0] ALU_ADD = 2'd0;
	localparam logic [1:0] ALU_SUB = 2'd1;
	localparam logic [1:0] ALU_MUL = 2'd2;
	localparam logic [1:0] ALU_DIV = 2'd3;

	// Instruction classes, matched against instruction bits 7..2 or 7..6.
	localparam logic [5:0] INSTR_IN    = 6'b110000; // 0xC0..0xC3
	localparam logic [5:0] INSTR_OUT   = 6'b110001; // 0xC4..0xC7
	localparam logic [1:0] INSTR_ARITH = 2'b10;     // 0x80..0xBF
	localparam logic [RegAddrW-1:0] REG_D = 2'd3;

	typedef struct packed {
		logic [DataW-1:0] instr;
		logic [DataW-1:0] in_value;
	} in_t;

	typedef struct packed {
		logic             out_valid;
		logic [DataW-1:0] out_value;
		logic [ErrW-1:0]  error_code;
	} out_t;

	// Request from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic             start;
		logic [1:0]       op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
	} alu_req_t;

endpackage

/* rtl/tacpu_alu.sv */
// Shared arithmetic unit: registered add/subtract, eight-step multiply and divide.
module tacpu_alu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tacpu_pkg::alu_req_t   req,
	output logic                  done,
	output logic [tacpu_pkg::DataW-1:0] result
);
	import tacpu_pkg::*;

	localparam int CntW = $clog2(DataW);
	localparam logic [CntW-1:0] LastStep = CntW'(DataW - 1);

	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [1:0]       op_q;
	logic [DataW-1:0] acc_q;   // product, or partial remainder
	logic [DataW-1:0] opa_q;   // multiplicand, or dividend/quotient
	logic [DataW-1:0] opb_q;   // multiplier, or divisor

	logic [DataW:0]   rem_sh;
	logic [DataW:0]   rem_diff;
	logic             rem_ge;

	// restoring divide step
	assign rem_sh   = {acc_q, opa_q[DataW-1]};
	assign rem_ge   = rem_sh >= {1'b0, opb_q};
	assign rem_diff = rem_sh - {1'b0, opb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.op == ALU_MUL || req.op == ALU_DIV) begin
					busy_q <= 1'b1;
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastStep) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			opa_q <= req.a;
			opb_q <= req.b;
			case (req.op)
				ALU_ADD: acc_q <= req.a + req.b;
				ALU_SUB: acc_q <= req.a - req.b;
				default: acc_q <= '0;
			endcase
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				acc_q <= acc_q + (opb_q[0] ? opa_q : '0);
				opa_q <= {opa_q[DataW-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[DataW-1:1]};
			end else begin
				acc_q <= rem_ge ? rem_diff[DataW-1:0] : rem_sh[DataW-1:0];
				opa_q <= {opa_q[DataW-2:0], rem_ge};
			end
		end
	end

	assign done   = done_q;
	assign result = (op_q == ALU_DIV) ? opa_q : acc_q;

endmodule

/* rtl/tiny_accumulator_cpu_execute.sv */
// Top level of the tiny accumulator CPU execute block.
// Executes one instruction beat at a time on four 8-bit registers A..D and
// returns exactly one result beat per instruction. The input side stalls
// from acceptance until the result is written into the output register:
// loads, input, output, invalid codes, divide by zero and halted beats
// pass accept, issue and finish; add and subtract also wait on the shared
// arithmetic unit; multiply and other divides wait out its eight shift-add
// or restoring-divide steps. A waiting result beat holds only the finish
// step, and the next instruction is accepted while it waits downstream.
// Divide by zero and any code from 0xC8 up halt the block until reset;
// after that every beat answers error code 3 and changes nothing.
`include "assert_macros.svh"

module tiny_accumulator_cpu_execute (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tacpu_pkg::in_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output tacpu_pkg::out_t   result
);
	import tacpu_pkg::*;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]          state_q;
	in_t                 op_q;        // instruction beat under execution
	logic                halted_q;

	// register file: memory plus valid bits that stand for the zero reset
	logic [DataW-1:0]    rf_mem [RegCount];
	logic [RegCount-1:0] rf_vld_q;
	logic [DataW-1:0]    rd_dst_q;
	logic [DataW-1:0]    rd_src_q;
	logic                rf_we;
	logic [RegAddrW-1:0] rf_waddr;
	logic [DataW-1:0]    rf_wdata;

	out_t                res_q;
	logic                res_valid_q;
	logic                out_free;

	alu_req_t            alu_req;
	logic                alu_done;
	logic [DataW-1:0]    alu_result;

	logic                accept;
	logic                is_arith;
	logic                div_zero;
	logic [RegAddrW-1:0] dst;
	logic [RegAddrW-1:0] src;
	out_t                res_d;
	logic                halt_d;

	assign accept     = item_valid && !item_stall;
	assign item_stall = state_q != ST_IDLE;
	assign out_free   = !res_valid_q || !result_stall;

	assign dst      = op_q.instr[3:2];
	assign src      = op_q.instr[1:0];
	assign is_arith = op_q.instr[7:6] == INSTR_ARITH;
	assign div_zero = is_arith && op_q.instr[5:4] == ALU_DIV && rd_src_q == '0;

	// the unit starts on every arithmetic beat that can complete
	assign alu_req.start = state_q == ST_ISSUE && !halted_q && is_arith && !div_zero;
	assign alu_req.op    = op_q.instr[5:4];
	assign alu_req.a     = rd_dst_q;
	assign alu_req.b     = rd_src_q;

	tacpu_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.done   (alu_done),
		.result (alu_result)
	);

	// Finish step: result beat, register write and halt decision.
	always_comb begin
		res_d      = '{out_valid: 1'b0, out_value: '0, error_code: ERR_NONE};
		rf_we      = 1'b0;
		rf_waddr   = REG_D;
		rf_wdata   = op_q.instr;
		halt_d     = 1'b0;
		if (halted_q) begin
			res_d.error_code = ERR_HALTED;
		end else if (!op_q.instr[DataW-1]) begin
			rf_we = 1'b1;     // immediate load into D
		end else if (op_q.instr[7:2] == INSTR_IN) begin
			rf_we    = 1'b1;
			rf_waddr = src;
			rf_wdata = op_q.in_value;
		end else if (op_q.instr[7:2] == INSTR_OUT) begin
			res_d.out_valid = 1'b1;
			res_d.out_value = rd_src_q;
		end else if (is_arith) begin
			if (div_zero) begin
				res_d.error_code = ERR_DIVZERO;
				halt_d           = 1'b1;
			end else begin
				rf_we    = 1'b1;
				rf_waddr = dst;
				rf_wdata = alu_result;
			end
		end else begin
			res_d.error_code = ERR_OPCODE;
			halt_d           = 1'b1;
		end
	end

	// sequencer, halt flag, output register control, register valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			halted_q    <= 1'b0;
			res_valid_q <= 1'b0;
			rf_vld_q    <= '0;
		end else begin
			// output register: loaded by the finish step, emptied when taken
			if (state_q == ST_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= alu_req.start ? ST_WAIT : ST_FIN;
				end
				ST_WAIT: begin
					if (alu_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (halt_d) begin
							halted_q <= 1'b1;
						end
						if (rf_we) begin
							rf_vld_q[rf_waddr] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers, register file write and registered reads
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= item;
			rd_dst_q <= rf_vld_q[item.instr[3:2]] ? rf_mem[item.instr[3:2]] : '0;
			rd_src_q <= rf_vld_q[item.instr[1:0]] ? rf_mem[item.instr[1:0]] : '0;
		end
		if (state_q == ST_FIN && out_free) begin
			res_q <= res_d;
			if (rf_we) begin
				rf_mem[rf_waddr] <= rf_wdata;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a new result beat only comes out of the finish step
	`TACPU_ASSERT(a_res_from_fin, clk, arst_n, $rose(result_valid) |-> $past(state_q) == ST_FIN, "result beat without finish step")
	// halt is sticky until reset
	`TACPU_ASSERT(a_halt_sticky, clk, arst_n, halted_q |=> halted_q, "halt flag cleared")
	// the arithmetic unit only completes while the sequencer waits for it
	`TACPU_NEVER(a_done_in_wait, clk, arst_n, alu_done && state_q != ST_WAIT, "unit done outside wait")

endmodule

/* verif/tiny_accumulator_cpu_execute_tb.sv */
// Self-checking testbench for the tiny accumulator CPU execute block.
module tiny_accumulator_cpu_execute_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tacpu_pkg::*;

	// Register indexes; D comes from the package
	localparam logic [RegAddrW-1:0] REG_A = 2'd0;
	localparam logic [RegAddrW-1:0] REG_B = 2'd1;
	localparam logic [RegAddrW-1:0] REG_C = 2'd2;
	// Lowest code that is neither a load, I/O nor arithmetic
	localparam logic [DataW-1:0] FIRST_BAD_CODE = 8'hC8;

	// Longest cycle count with no beat moving on either side before we give up.
	// The slowest legal case is a multiply/divide behind the long result
	// hold-off, and the limit leaves plenty of margin over it.
	localparam int STUCK_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;   // long receiver hold-off
	localparam int TAIL_CYCLES = 20;   // settle time after the last result
	localparam int RANDOM_BEATS = 370; // per idle mix

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	in_t     item;
	logic    result_valid;
	logic    result_stall;
	out_t    result;

	// Shadow CPU state, advanced once per accepted instruction beat
	logic [DataW-1:0] cpu_regs [RegCount];
	logic             cpu_halted;

	// Result beats the block still owes us, oldest first
	out_t due_results[$];
	out_t want;

	int send_gap_pct;
	int recv_stall_pct;
	bit hold_req;
	int fail_count;
	int stuck_cycles;

	// Run statistics for the closing summary
	int n_exec;
	int n_emits;
	int n_arith;
	int n_halted_beats;
	string halt_cause;

	tiny_accumulator_cpu_execute u_dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Instruction encoders
	// ------------------------------------------------------------------
	function automatic logic [DataW-1:0] load_code(input logic [6:0] imm);
		return {1'b0, imm};
	endfunction

	function automatic logic [DataW-1:0] in_code(input logic [RegAddrW-1:0] r);
		return {INSTR_IN, r};
	endfunction

	function automatic logic [DataW-1:0] out_code(input logic [RegAddrW-1:0] r);
		return {INSTR_OUT, r};
	endfunction

	function automatic logic [DataW-1:0] arith_code(input logic [1:0] op,
			input logic [RegAddrW-1:0] dst, input logic [RegAddrW-1:0] src);
		return {INSTR_ARITH, op, dst, src};
	endfunction

	// Random byte for a payload field
	function automatic logic [DataW-1:0] rand_byte();
		return DataW'($urandom_range(255));
	endfunction

	// ------------------------------------------------------------------
	// Execute one instruction on the shadow state and return the result
	// beat the block must produce for it.
	// ------------------------------------------------------------------
	function automatic out_t run_instr(input in_t beat);
		out_t                res;
		logic [DataW-1:0]    lhs;
		logic [DataW-1:0]    rhs;
		logic [RegAddrW-1:0] dst;
		logic [RegAddrW-1:0] src;
		res = '0;
		dst = beat.instr[3:2];
		src = beat.instr[1:0];
		lhs = cpu_regs[dst];
		rhs = cpu_regs[src];
		if (cpu_halted) begin
			// sticky: nothing changes until reset
			res.error_code = ERR_HALTED;
		end else if (beat.instr[7] == 1'b0) begin
			cpu_regs[REG_D] = {1'b0, beat.instr[6:0]};
		end else if (beat.instr[7:2] == INSTR_IN) begin
			cpu_regs[src] = beat.in_value;
		end else if (beat.instr[7:2] == INSTR_OUT) begin
			res.out_valid = 1'b1;
			res.out_value = rhs;
		end else if (beat.instr[7:6] == INSTR_ARITH) begin
			case (beat.instr[5:4])
				ALU_ADD: cpu_regs[dst] = lhs + rhs;
				ALU_SUB: cpu_regs[dst] = lhs - rhs;
				ALU_MUL: cpu_regs[dst] = lhs * rhs;
				ALU_DIV: begin
					if (rhs == '0) begin
						cpu_halted = 1'b1;
						res.error_code = ERR_DIVZERO;
					end else begin
						cpu_regs[dst] = lhs / rhs;
					end
				end
				default: ;
			endcase
		end else begin
			cpu_halted = 1'b1;
			res.error_code = ERR_OPCODE;
		end
		return res;
	endfunction

	// Well-formed random instruction that never halts the block: a divide
	// whose source is zero is steered to a nonzero source, or made an add.
	function automatic logic [DataW-1:0] pick_exec_code();
		int unsigned         kind;
		logic [1:0]          op;
		logic [RegAddrW-1:0] dst;
		logic [RegAddrW-1:0] src;
		kind = $urandom_range(99);
		op   = 2'($urandom_range(3));
		dst  = RegAddrW'($urandom_range(3));
		src  = RegAddrW'($urandom_range(3));
		if (kind < 15)
			return load_code(7'($urandom_range(127)));
		if (kind < 40)
			return in_code(src);
		if (kind < 58)
			return out_code(src);
		if (op == ALU_DIV && cpu_regs[src] == '0) begin
			op = ALU_ADD;
			for (int r = 0; r < RegCount; r++) begin
				if (cpu_regs[r] != '0) begin
					op  = ALU_DIV;
					src = RegAddrW'(r);
				end
			end
		end
		return arith_code(op, dst, src);
	endfunction

	// ------------------------------------------------------------------
	// Sender: drives at the falling edge, sees acceptance at the rising edge.
	// Valid stays up after acceptance only until the next falling edge,
	// where the next call either lowers it or puts up the next beat.
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [DataW-1:0] code, input logic [DataW-1:0] val);
		in_t  beat;
		out_t res;
		beat.instr    = code;
		beat.in_value = val;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			item       <= in_t'({rand_byte(), rand_byte()});
			@(negedge clk);
		end
		item       <= beat;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (cpu_halted)
			n_halted_beats++;
		else begin
			n_exec++;
			if (beat.instr[7:6] == INSTR_ARITH)
				n_arith++;
		end
		res = run_instr(beat);
		if (res.out_valid)
			n_emits++;
		due_results.push_back(res);
	endtask

	// Lower valid and hold off until every owed result has come back
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, every instruction class and every ALU op, with
	// wrap-around on add, subtract and multiply. No halt here.
	task automatic test_directed_ops();
		send_beat(load_code('0), '0);
		send_beat(load_code('1), '1);
		send_beat(in_code(REG_A), 8'hFF);
		send_beat(in_code(REG_B), 8'h00);
		send_beat(in_code(REG_C), 8'hAA);
		send_beat(in_code(REG_D), 8'h55);
		for (int r = 0; r < RegCount; r++)
			send_beat(out_code(RegAddrW'(r)), rand_byte());
		send_beat(arith_code(ALU_ADD, REG_A, REG_A), '0); // 255+255 wraps
		send_beat(arith_code(ALU_SUB, REG_A, REG_B), '0);
		send_beat(arith_code(ALU_SUB, REG_B, REG_A), '0); // 0-254 wraps
		send_beat(arith_code(ALU_MUL, REG_D, REG_C), '0);
		send_beat(arith_code(ALU_DIV, REG_A, REG_C), '0);
		send_beat(arith_code(ALU_DIV, REG_C, REG_A), '0); // divide by one
		send_beat(arith_code(ALU_DIV, REG_D, REG_D), '0);
		send_beat(arith_code(ALU_DIV, REG_A, REG_B), '0); // quotient zero
		send_beat(in_code(REG_B), 8'hFF);
		send_beat(arith_code(ALU_MUL, REG_B, REG_B), '0); // 255*255 -> 1
		for (int r = 0; r < RegCount; r++)
			send_beat(out_code(RegAddrW'(r)), rand_byte());
	endtask

	// Random well-formed program under one idle mix
	task automatic test_random_traffic(input int gap_pct, input int stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < RANDOM_BEATS; n++)
			send_beat(pick_exec_code(), rand_byte());
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the output register fills and the input side stalls; then the
	// sender pauses until everything owed has come out.
	task automatic test_backpressure();
		send_gap_pct = 0;
		hold_req = 1'b1;
		for (int n = 0; n < 12; n++)
			send_beat(pick_exec_code(), rand_byte());
		wait_drained();
	endtask

	// One halt, either cause picked at random, then full-range noise that
	// must all answer "already halted" with no output.
	task automatic test_halt();
		send_gap_pct   = 10;
		recv_stall_pct = 30;
		if ($urandom_range(1) == 0) begin
			halt_cause = "divide by zero";
			send_beat(in_code(REG_A), '0);
			send_beat(arith_code(ALU_DIV, REG_B, REG_A), rand_byte());
		end else begin
			halt_cause = "invalid opcode";
			send_beat(DataW'($urandom_range(255, FIRST_BAD_CODE)), rand_byte());
		end
		send_beat(out_code(REG_D), '0);
		send_beat(arith_code(ALU_DIV, REG_A, REG_A), '0);
		for (int n = 0; n < 24; n++)
			send_beat(rand_byte(), rand_byte());
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall per cycle, or a long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted result beat against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				$error("result beat with nothing owed: %p", result);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (result.out_valid !== want.out_valid) begin
					$error("out_valid: expected %0d, got %0d", want.out_valid,
						result.out_valid);
					fail_count++;
				end
				if (result.out_value !== want.out_value) begin
					$error("out_value: expected 0x%02h, got 0x%02h", want.out_value,
						result.out_value);
					fail_count++;
				end
				if (result.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						result.error_code);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run when no beat moves for too long
	// ------------------------------------------------------------------
	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		hold_req       = 1'b0;
		send_gap_pct   = 20;
		recv_stall_pct = 30;
		fail_count     = 0;
		n_exec         = 0;
		n_emits        = 0;
		n_arith        = 0;
		n_halted_beats = 0;
		halt_cause     = "none";
		cpu_halted     = 1'b0;
		for (int r = 0; r < RegCount; r++)
			cpu_regs[r] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_random_traffic(28, 69);
		test_backpressure();
		test_random_traffic(69, 28);
		test_random_traffic(0, 0);
		test_halt();

		// everything sent: collect what is owed, then let the pipe settle
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Executed %0d instructions (%0d arithmetic, %0d emits) under three idle mixes",
			n_exec, n_arith, n_emits);
		$display("and a long result hold-off; halted by %s, then %0d beats while halted.",
			halt_cause, n_halted_beats);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
